// File: rtl/hcc_pkg.sv
package hcc_pkg;

  // Significant bits of a code unit; all 16 bits of the input are used.
  localparam int CHAR_BITS = 16;
  localparam logic [15:0] CH_MASK = 16'((33'd1 << CHAR_BITS) - 33'd1);

  localparam logic [15:0] CH_LT   = 16'h003C;
  localparam logic [15:0] CH_GT   = 16'h003E;
  localparam logic [15:0] CH_BANG = 16'h0021;
  localparam logic [15:0] CH_DASH = 16'h002D;
  localparam logic [15:0] CH_AMP  = 16'h0026;
  localparam logic [15:0] CH_SEMI = 16'h003B;
  localparam logic [15:0] CH_APOS = 16'h0027;
  localparam logic [15:0] CH_QUOT = 16'h0022;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_TAG     = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CLS_PLAIN   = 3'd0,
    CLS_ENTITY  = 3'd1,
    CLS_TAG     = 3'd2,
    CLS_ATTR    = 3'd3,
    CLS_COMMENT = 3'd4
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [15:0] quote;
    logic        space;
    logic        closes;
  } tag_res_t;

  // Characters of the comment opener "<!--", by position.
  function automatic logic [15:0] opener(logic [1:0] idx);
    logic [15:0] r;
    unique case (idx)
      2'd0: r = CH_LT;
      2'd1: r = CH_BANG;
      default: r = CH_DASH;
    endcase
    return r;
  endfunction

  function automatic logic is_ws(logic [15:0] c);
    return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h00A0 ||
           c == 16'h1680 || c == 16'h180E || (c >= 16'h2000 && c <= 16'h200A) ||
           c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
           c == 16'h3000;
  endfunction

  // One character inside a tag: track quotes and the first whitespace.
  function automatic tag_res_t tag_char(logic [15:0] c, logic last,
                                        logic [15:0] quote, logic space);
    tag_res_t r;
    logic     closes;
    r.quote = quote;
    r.space = space;
    closes  = 1'b0;
    if (quote == 16'h0000) begin
      if (c == CH_APOS || c == CH_QUOT) r.quote = c;
      else if (is_ws(c) && !space) r.space = 1'b1;
      else if (c == CH_GT) closes = 1'b1;
    end else begin
      if (is_ws(c) && !space) r.space = 1'b1;
      else if (c == quote) r.quote = 16'h0000;
    end
    r.cls    = (r.space && !closes && !last) ? CLS_ATTR : CLS_TAG;
    r.closes = closes;
    if (closes) begin
      r.quote = 16'h0000;
      r.space = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/html_char_classifier_core.sv
// HTML character classifier.
//
// Input stream (s_*): one UTF-16 code unit per transfer in s_tdata, with
// s_tlast marking the last character of a text line. Output stream (m_*):
// each input causes zero to four results, one per transfer, holding the
// character and its class (plain, entity, tag, attribute, comment);
// m_tlast flags the final result caused by one input.
//
// An accepted character waits in the input register until the result group
// register is free; its results are then loaded into the result group, whose
// entry 0 drives the output.
// Throughput: one input per cycle while each input gives at most one result
// and m_tready stays high; an input that flushes a held "<" prefix gives up
// to four results, and the next input waits until the last of them leaves,
// since the result group drains one entry per transfer.
// A "<" is held with no result until the next characters decide "<!--".
//
// Reset (rst, synchronous) empties both registers and returns the lexer to
// normal text with no held prefix. When m_tready is low the result group
// holds, the input register fills once, and s_tready then drops.
module html_char_classifier_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] char_code
  input  logic        s_tlast,   // line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] out_char, [18:16] char_class, rest zero
  output logic        m_tlast    // last_of_run
);
  import hcc_pkg::*;

  // Input register
  logic        in_valid;
  logic [15:0] in_char;
  logic        in_last;

  // Lexer state
  mode_t       mode, mode_next;
  logic        ent, ent_next;
  logic [1:0]  held, held_next;
  logic [1:0]  dash, dash_next;
  logic [15:0] quote, quote_next;
  logic        space, space_next;

  // Results of the item in the input register
  logic [15:0] res_char [4];
  cls_t        res_cls  [4];
  logic [2:0]  res_n;

  // Result group: entry 0 is on the output, the rest wait behind it
  logic [15:0] g_char [4];
  cls_t        g_cls  [4];
  logic [2:0]  g_cnt;

  logic        process;

  // Load a new group once the current one is gone or leaves this cycle.
  assign process  = in_valid && ((g_cnt == 3'd0) || (g_cnt == 3'd1 && m_tready));
  assign s_tready = !in_valid || process;

  assign m_tvalid = (g_cnt != 3'd0);
  assign m_tlast  = (g_cnt == 3'd1);
  assign m_tdata  = {5'b00000, g_cls[0], g_char[0]};

  always_comb begin : classify
    tag_res_t    tr;
    logic [15:0] c;
    logic        do_disp;
    logic [1:0]  k;
    mode_next  = mode;
    ent_next   = ent;
    held_next  = held;
    dash_next  = dash;
    quote_next = quote;
    space_next = space;
    res_n      = 3'd0;
    do_disp    = 1'b0;
    tr         = '0;
    for (int i = 0; i < 4; i++) begin
      res_char[i] = 16'h0000;
      res_cls[i]  = CLS_PLAIN;
    end
    c = in_char & CH_MASK;

    priority if (held != 2'd0) begin
      if (c == opener(held) && held == 2'd3) begin
        // Full "<!--": all four characters are comment; its dashes count.
        for (int i = 0; i < 3; i++) begin
          res_char[i] = opener(2'(i));
          res_cls[i]  = CLS_COMMENT;
        end
        res_char[3] = c;
        res_cls[3]  = CLS_COMMENT;
        res_n       = 3'd4;
        held_next   = 2'd0;
        mode_next   = MODE_COMMENT;
        dash_next   = 2'd2;
      end else if (c == opener(held) && !in_last) begin
        held_next = 2'(held + 2'd1);
      end else begin
        // Prefix broken: replay the held characters as tag characters.
        held_next = 2'd0;
        mode_next = MODE_TAG;
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < held) begin
            tr          = tag_char(opener(2'(i)), 1'b0, quote_next, space_next);
            res_char[i] = opener(2'(i));
            res_cls[i]  = tr.cls;
            quote_next  = tr.quote;
            space_next  = tr.space;
            if (tr.closes) mode_next = MODE_NORMAL;
          end
        end
        res_n   = {1'b0, held};
        do_disp = 1'b1;
      end
    end else begin
      do_disp = 1'b1;
    end

    k = res_n[1:0];
    if (do_disp) begin
      priority if (mode_next == MODE_COMMENT) begin
        if (c == CH_DASH) begin
          if (dash_next < 2'd2) dash_next = 2'(dash_next + 2'd1);
        end else if (c == CH_GT && dash_next >= 2'd2) begin
          mode_next = MODE_NORMAL;
          dash_next = 2'd0;
        end else begin
          dash_next = 2'd0;
        end
        res_char[k] = c;
        res_cls[k]  = CLS_COMMENT;
        res_n       = 3'(res_n + 3'd1);
      end else if (mode_next == MODE_TAG) begin
        tr          = tag_char(c, in_last, quote_next, space_next);
        quote_next  = tr.quote;
        space_next  = tr.space;
        if (tr.closes) mode_next = MODE_NORMAL;
        res_char[k] = c;
        res_cls[k]  = tr.cls;
        res_n       = 3'(res_n + 3'd1);
      end else if (ent_next) begin
        if (c == CH_SEMI) ent_next = 1'b0;
        res_char[k] = c;
        res_cls[k]  = CLS_ENTITY;
        res_n       = 3'(res_n + 3'd1);
      end else if (c == CH_AMP) begin
        ent_next    = 1'b1;
        res_char[k] = c;
        res_cls[k]  = CLS_ENTITY;
        res_n       = 3'(res_n + 3'd1);
      end else if (c == CH_LT) begin
        if (in_last) begin
          // No room left on the line for "<!--": plain tag opener.
          mode_next   = MODE_TAG;
          tr          = tag_char(c, 1'b1, quote_next, space_next);
          quote_next  = tr.quote;
          space_next  = tr.space;
          if (tr.closes) mode_next = MODE_NORMAL;
          res_char[k] = c;
          res_cls[k]  = tr.cls;
          res_n       = 3'(res_n + 3'd1);
        end else begin
          held_next = 2'd1;
        end
      end else begin
        res_char[k] = c;
        res_cls[k]  = CLS_PLAIN;
        res_n       = 3'(res_n + 3'd1);
      end
    end

    // Line end keeps only the mode.
    if (in_last) begin
      ent_next   = 1'b0;
      held_next  = 2'd0;
      dash_next  = 2'd0;
      quote_next = 16'h0000;
      space_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_NORMAL;
      ent   <= 1'b0;
      held  <= 2'd0;
      dash  <= 2'd0;
      quote <= 16'h0000;
      space <= 1'b0;
    end else if (process) begin
      mode  <= mode_next;
      ent   <= ent_next;
      held  <= held_next;
      dash  <= dash_next;
      quote <= quote_next;
      space <= space_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_cnt <= 3'd0;
    end else if (process) begin
      g_cnt <= res_n;
    end else if (m_tvalid && m_tready) begin
      g_cnt <= 3'(g_cnt - 3'd1);
    end
  end

  // Load a fresh group, or advance the queue by one on each transfer.
  always_ff @(posedge clk) begin
    if (process) begin
      for (int i = 0; i < 4; i++) begin
        g_char[i] <= res_char[i];
        g_cls[i]  <= res_cls[i];
      end
    end else if (m_tvalid && m_tready) begin
      for (int i = 0; i < 3; i++) begin
        g_char[i] <= g_char[i + 1];
        g_cls[i]  <= g_cls[i + 1];
      end
    end
  end

endmodule
